// ===== hw/rtl/lsms_pkg.sv =====
// shared types and constants for the two-light diffuse shading block
`timescale 1ns / 1ps

package lsms_pkg;

   // lane layout of the packed registers and fields
   localparam int LANE_W    = 16;
   localparam int PACKED_W  = 48;
   localparam int FILL_W    = 32;
   localparam int LIGHT_W   = 15;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHTING_ENABLE = 3'd0,
      CSR_SUN_DIRECTION   = 3'd1,
      CSR_MOON_DIRECTION  = 3'd2,
      CSR_AMBIENT_COLOR   = 3'd3,
      CSR_SUN_COLOR       = 3'd4,
      CSR_MOON_COLOR      = 3'd5,
      CSR_SKY_FILL        = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [PACKED_W-1:0] DIRECTION_RESET = 48'h0000_4000_0000;
   localparam logic [FILL_W-1:0]   SKY_FILL_RESET  = 32'h1CCD_2333;

   // load strobes of the two dot product stages
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_ctrl_type;

endpackage

// ===== hw/rtl/lsms_ndotl.sv =====
// two-stage clamped n.l dot product plus sky fill weight for one light
`timescale 1ns / 1ps

module lsms_ndotl #(
   parameter int FRACTION_BITS = 14,
   localparam int DOT_W = 2 * lsms_pkg::LANE_W + 2,
   localparam int NDL_W = DOT_W - FRACTION_BITS,
   localparam int WGT_W = ((NDL_W > lsms_pkg::LANE_W) ? NDL_W : lsms_pkg::LANE_W) + 1
) (
   input  logic                                clock,
   input  lsms_pkg::stage_ctrl_type            ctrl,
   input  logic signed [lsms_pkg::LANE_W-1:0]  normal_x,
   input  logic signed [lsms_pkg::LANE_W-1:0]  normal_y,
   input  logic signed [lsms_pkg::LANE_W-1:0]  normal_z,
   input  logic [lsms_pkg::PACKED_W-1:0]       light_dir,
   input  logic [lsms_pkg::LANE_W-1:0]         fill_weight,
   output logic [WGT_W-1:0]                    weight
);

   localparam int PROD_W = 2 * lsms_pkg::LANE_W;

   logic signed [lsms_pkg::LANE_W-1:0] normal[3];
   logic signed [lsms_pkg::LANE_W-1:0] dir_lane[3];
   logic signed [PROD_W-1:0]           prod_in[3];
   logic signed [PROD_W-1:0]           prod_ff[3];
   logic signed [DOT_W-1:0]            dot_sum;
   logic [NDL_W-1:0]                   ndl;
   logic [WGT_W-1:0]                   weight_in;
   logic [WGT_W-1:0]                   weight_ff;

   assign normal[0] = normal_x;
   assign normal[1] = normal_y;
   assign normal[2] = normal_z;

   // component products, one multiplier per axis
   for (genvar k = 0; k < 3; k++) begin : g_axis
      assign dir_lane[k] = light_dir[lsms_pkg::LANE_W*k +: lsms_pkg::LANE_W];
      assign prod_in[k]  = normal[k] * dir_lane[k];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         prod_ff <= prod_in;
      end
   end

   // sum, clamp negative to zero, truncate, add fill
   always_comb begin
      dot_sum = {{2{prod_ff[0][PROD_W-1]}}, prod_ff[0]}
              + {{2{prod_ff[1][PROD_W-1]}}, prod_ff[1]}
              + {{2{prod_ff[2][PROD_W-1]}}, prod_ff[2]};
      ndl = dot_sum[DOT_W-1] ? '0 : dot_sum[DOT_W-1:FRACTION_BITS];
      weight_in = WGT_W'(fill_weight) + WGT_W'(ndl);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_b) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

// ===== hw/rtl/lambert_sun_moon_shading.sv =====
// top level of the two-light lambertian shading pipeline with csr block
`timescale 1ns / 1ps

// Diffuse shading of one normal per clock while the pipeline is not held: each colour
// channel is ambient*floor + sun*(fill + max(n.l,0)) + moon*(fill + max(n.l,0)),
// rounded and saturated to one, or full white while lighting_enable is clear. The
// pipeline has four register stages (axis products, light weights, colour products,
// channel sum and output), and a new transaction is taken every cycle unless the
// pipeline is held; a stalled output only holds the pipeline once every stage is
// occupied, as the bubbles collapse first. csr_ready is always high. The user must
// write registers through the csr port only while no transaction is in flight; the
// block itself does not enforce this.
module lambert_sun_moon_shading #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lsms_pkg::LANE_W-1:0]  req_normal_x,
   input  logic signed [lsms_pkg::LANE_W-1:0]  req_normal_y,
   input  logic signed [lsms_pkg::LANE_W-1:0]  req_normal_z,
   input  logic signed [lsms_pkg::LANE_W-1:0]  req_shade_floor,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lsms_pkg::LIGHT_W-1:0]        rsp_red_light,
   output logic [lsms_pkg::LIGHT_W-1:0]        rsp_green_light,
   output logic [lsms_pkg::LIGHT_W-1:0]        rsp_blue_light,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsms_pkg::PACKED_W-1:0]       csr_data
);

   localparam int LANE_W  = lsms_pkg::LANE_W;
   localparam int DOT_W   = 2 * LANE_W + 2;
   localparam int NDL_W   = DOT_W - FRACTION_BITS;
   localparam int WGT_W   = ((NDL_W > LANE_W) ? NDL_W : LANE_W) + 1;
   localparam int AMB_W   = 2 * LANE_W;
   localparam int LP_W    = LANE_W + WGT_W;
   localparam int ACC_W   = LP_W + 2;
   localparam int RND_W   = ACC_W + 1;
   localparam int CMP_W   = (FRACTION_BITS + 1 > LANE_W) ? FRACTION_BITS + 1 : LANE_W;
   localparam logic [RND_W-1:0] ONE_EXT  = RND_W'(1) << FRACTION_BITS;
   localparam logic [RND_W-1:0] HALF_EXT = RND_W'(1) << (FRACTION_BITS - 1);
   localparam logic [CMP_W-1:0] ONE_CMP  = CMP_W'(1) << FRACTION_BITS;

   // configuration registers
   logic                            lighting_enable_ff;
   logic [lsms_pkg::PACKED_W-1:0]   sun_dir_ff;
   logic [lsms_pkg::PACKED_W-1:0]   moon_dir_ff;
   logic [lsms_pkg::PACKED_W-1:0]   ambient_col_ff;
   logic [lsms_pkg::PACKED_W-1:0]   sun_col_ff;
   logic [lsms_pkg::PACKED_W-1:0]   moon_col_ff;
   logic [lsms_pkg::FILL_W-1:0]     sky_fill_ff;

   // pipeline control
   logic valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;
   logic load_a, load_b, load_c, load_d;
   lsms_pkg::stage_ctrl_type dot_ctrl;

   // payload
   logic [CMP_W-1:0]    floor_cmp;
   logic [LANE_W-1:0]   floor_in;
   logic [LANE_W-1:0]   floor_a_ff;
   logic [LANE_W-1:0]   floor_b_ff;
   logic [WGT_W-1:0]    sun_weight;
   logic [WGT_W-1:0]    moon_weight;
   logic [AMB_W-1:0]    amb_prod_ff[3];
   logic [LP_W-1:0]     sun_prod_ff[3];
   logic [LP_W-1:0]     moon_prod_ff[3];
   logic [lsms_pkg::LIGHT_W-1:0] light_in[3];
   logic [lsms_pkg::LIGHT_W-1:0] light_ff[3];

   // csr writes, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lighting_enable_ff <= 1'b0;
         sun_dir_ff         <= lsms_pkg::DIRECTION_RESET;
         moon_dir_ff        <= lsms_pkg::DIRECTION_RESET;
         ambient_col_ff     <= '0;
         sun_col_ff         <= '0;
         moon_col_ff        <= '0;
         sky_fill_ff        <= lsms_pkg::SKY_FILL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lsms_pkg::CSR_LIGHTING_ENABLE: lighting_enable_ff <= csr_data[0];
            lsms_pkg::CSR_SUN_DIRECTION:   sun_dir_ff         <= csr_data;
            lsms_pkg::CSR_MOON_DIRECTION:  moon_dir_ff        <= csr_data;
            lsms_pkg::CSR_AMBIENT_COLOR:   ambient_col_ff     <= csr_data;
            lsms_pkg::CSR_SUN_COLOR:       sun_col_ff         <= csr_data;
            lsms_pkg::CSR_MOON_COLOR:      moon_col_ff        <= csr_data;
            lsms_pkg::CSR_SKY_FILL:        sky_fill_ff        <= csr_data[lsms_pkg::FILL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage loads, a stage moves when empty or when the next one moves
   assign load_d    = !valid_d_ff || !rsp_stall;
   assign load_c    = !valid_c_ff || load_d;
   assign load_b    = !valid_b_ff || load_c;
   assign load_a    = !valid_a_ff || load_b;
   assign req_stall = !load_a;

   assign dot_ctrl.load_a = load_a;
   assign dot_ctrl.load_b = load_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         if (load_a) valid_a_ff <= req_valid;
         if (load_b) valid_b_ff <= valid_a_ff;
         if (load_c) valid_c_ff <= valid_b_ff;
         if (load_d) valid_d_ff <= valid_c_ff;
      end
   end

   // ambient floor clamp to [0, one]
   always_comb begin
      floor_cmp = CMP_W'(req_shade_floor[LANE_W-2:0]);
      if (req_shade_floor[LANE_W-1]) begin
         floor_in = '0;
      end else if (floor_cmp > ONE_CMP) begin
         floor_in = LANE_W'(ONE_CMP);
      end else begin
         floor_in = floor_cmp[LANE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) floor_a_ff <= floor_in;
      if (load_b) floor_b_ff <= floor_a_ff;
   end

   // light weights
   lsms_ndotl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_sun_ndotl (
      .clock       (clock),
      .ctrl        (dot_ctrl),
      .normal_x    (req_normal_x),
      .normal_y    (req_normal_y),
      .normal_z    (req_normal_z),
      .light_dir   (sun_dir_ff),
      .fill_weight (sky_fill_ff[LANE_W-1:0]),
      .weight      (sun_weight)
   );

   lsms_ndotl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_moon_ndotl (
      .clock       (clock),
      .ctrl        (dot_ctrl),
      .normal_x    (req_normal_x),
      .normal_y    (req_normal_y),
      .normal_z    (req_normal_z),
      .light_dir   (moon_dir_ff),
      .fill_weight (sky_fill_ff[2*LANE_W-1:LANE_W]),
      .weight      (moon_weight)
   );

   // per channel products, then rounded and saturated sum
   for (genvar c = 0; c < 3; c++) begin : g_channel
      logic [LANE_W-1:0] amb_lane;
      logic [LANE_W-1:0] sun_lane;
      logic [LANE_W-1:0] moon_lane;
      logic [ACC_W-1:0]  acc;
      logic [RND_W-1:0]  rnd;
      logic [RND_W-1:0]  sat;

      assign amb_lane  = ambient_col_ff[LANE_W*c +: LANE_W];
      assign sun_lane  = sun_col_ff[LANE_W*c +: LANE_W];
      assign moon_lane = moon_col_ff[LANE_W*c +: LANE_W];

      always_ff @(posedge clock) begin
         if (load_c) begin
            amb_prod_ff[c]  <= AMB_W'(amb_lane) * AMB_W'(floor_b_ff);
            sun_prod_ff[c]  <= LP_W'(sun_lane) * LP_W'(sun_weight);
            moon_prod_ff[c] <= LP_W'(moon_lane) * LP_W'(moon_weight);
         end
      end

      always_comb begin
         acc = ACC_W'(amb_prod_ff[c]) + ACC_W'(sun_prod_ff[c]) + ACC_W'(moon_prod_ff[c]);
         rnd = (RND_W'(acc) + HALF_EXT) >> FRACTION_BITS;
         sat = (rnd > ONE_EXT) ? ONE_EXT : rnd;
         light_in[c] = lighting_enable_ff ? sat[lsms_pkg::LIGHT_W-1:0]
                                          : ONE_EXT[lsms_pkg::LIGHT_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (load_d) light_ff[c] <= light_in[c];
      end
   end

   assign rsp_valid       = valid_d_ff;
   assign rsp_red_light   = light_ff[0];
   assign rsp_green_light = light_ff[1];
   assign rsp_blue_light  = light_ff[2];

   // input is only held off when every stage is occupied and the output is stalled
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_a_ff && valid_b_ff && valid_c_ff && valid_d_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // an accepted transaction enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_a_ff)
      else $error("accepted transaction lost at the first stage");

   // a finished sum reaches the output when the output is not stalled
   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (valid_c_ff && !rsp_stall) |=> rsp_valid)
      else $error("channel sum not moved to the output");

endmodule
